/* rtl/core/slcp_pkg.sv */
// Shared types and constants for the sparse log-linear class probability unit.
// Holds the controller states, datapath command and status bundles, and the
// reciprocal table used by the exponential series. No dependencies.
package slcp_pkg;

  localparam int WEIGHT_COUNT_DEF = 4096;
  localparam int IDX_W            = 12;
  localparam int WGT_W            = 24;
  localparam int SUM_W            = 56;
  localparam int PROB_W           = 16;
  localparam int DVD_W            = 72;
  localparam int TERM_W           = 31;
  localparam int SER_W            = 32;
  localparam int ACC_W            = 88;
  localparam int RCP_W            = 36;

  localparam logic signed [WGT_W-1:0] CLAMP_HI = 24'sd1048575;
  localparam logic signed [WGT_W-1:0] CLAMP_LO = -24'sd1048576;
  localparam logic [TERM_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [RCP_W-1:0] ONE35 = 36'h8_0000_0000;

  localparam logic [RCP_W-1:0] RECIP_TBL [16] = '{
    ONE35 / 36'd1,  ONE35 / 36'd2,  ONE35 / 36'd3,  ONE35 / 36'd4,
    ONE35 / 36'd5,  ONE35 / 36'd6,  ONE35 / 36'd7,  ONE35 / 36'd8,
    ONE35 / 36'd9,  ONE35 / 36'd10, ONE35 / 36'd11, ONE35 / 36'd12,
    ONE35 / 36'd13, ONE35 / 36'd14, ONE35 / 36'd15, ONE35 / 36'd16
  };

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_CLAMP, S_SMUL, S_SRCP, S_SDIV, S_PCHK, S_PMLO,
    S_PMHI, S_FIN, S_EDIV, S_ADD, S_RLOAD, S_RDIV, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACC, OP_CLAMP, OP_SMUL, OP_SRCP, OP_SSTEP, OP_PMLO,
    OP_PMHI, OP_FIN, OP_DIVSTEP, OP_ADD, OP_RLOAD, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept_en;
  } cmd_t;

  typedef struct packed {
    logic closing;
    logic last_ex;
    logic series_last;
    logic series_second;
    logic n_zero;
    logic neg;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/slcp_ctrl.sv */
// Controller state machine for the class probability unit.
// Sequences the datapath through accumulate, exponential, sum and divide steps.
// Depends on slcp_pkg.
module slcp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             in_kind,
  input  slcp_pkg::status_t sts,
  output slcp_pkg::cmd_t    cmd
);

  slcp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slcp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slcp_pkg::S_IDLE:  if (in_fire && in_kind) state_nxt = slcp_pkg::S_ACC;
      slcp_pkg::S_ACC:   state_nxt = sts.closing ? slcp_pkg::S_CLAMP : slcp_pkg::S_IDLE;
      slcp_pkg::S_CLAMP: state_nxt = slcp_pkg::S_SMUL;
      slcp_pkg::S_SMUL:  state_nxt = slcp_pkg::S_SRCP;
      slcp_pkg::S_SRCP:  state_nxt = slcp_pkg::S_SDIV;
      slcp_pkg::S_SDIV: begin
        if (sts.series_last && sts.series_second) state_nxt = slcp_pkg::S_PCHK;
        else state_nxt = slcp_pkg::S_SMUL;
      end
      slcp_pkg::S_PCHK:  state_nxt = sts.n_zero ? slcp_pkg::S_FIN : slcp_pkg::S_PMLO;
      slcp_pkg::S_PMLO:  state_nxt = slcp_pkg::S_PMHI;
      slcp_pkg::S_PMHI:  state_nxt = slcp_pkg::S_PCHK;
      slcp_pkg::S_FIN:   state_nxt = sts.neg ? slcp_pkg::S_EDIV : slcp_pkg::S_ADD;
      slcp_pkg::S_EDIV:  if (sts.div_last) state_nxt = slcp_pkg::S_ADD;
      slcp_pkg::S_ADD:   state_nxt = sts.last_ex ? slcp_pkg::S_RLOAD : slcp_pkg::S_IDLE;
      slcp_pkg::S_RLOAD: state_nxt = slcp_pkg::S_RDIV;
      slcp_pkg::S_RDIV:  if (sts.div_last) state_nxt = slcp_pkg::S_OUT;
      slcp_pkg::S_OUT:   if (sts.out_free) state_nxt = slcp_pkg::S_IDLE;
      default:           state_nxt = slcp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept_en = 1'b0;
    cmd.op        = slcp_pkg::OP_NONE;
    unique case (state_r)
      slcp_pkg::S_IDLE:  cmd.accept_en = rst_n;
      slcp_pkg::S_ACC:   cmd.op = slcp_pkg::OP_ACC;
      slcp_pkg::S_CLAMP: cmd.op = slcp_pkg::OP_CLAMP;
      slcp_pkg::S_SMUL:  cmd.op = slcp_pkg::OP_SMUL;
      slcp_pkg::S_SRCP:  cmd.op = slcp_pkg::OP_SRCP;
      slcp_pkg::S_SDIV:  cmd.op = slcp_pkg::OP_SSTEP;
      slcp_pkg::S_PCHK:  cmd.op = slcp_pkg::OP_NONE;
      slcp_pkg::S_PMLO:  cmd.op = slcp_pkg::OP_PMLO;
      slcp_pkg::S_PMHI:  cmd.op = slcp_pkg::OP_PMHI;
      slcp_pkg::S_FIN:   cmd.op = slcp_pkg::OP_FIN;
      slcp_pkg::S_EDIV:  cmd.op = slcp_pkg::OP_DIVSTEP;
      slcp_pkg::S_ADD:   cmd.op = slcp_pkg::OP_ADD;
      slcp_pkg::S_RLOAD: cmd.op = slcp_pkg::OP_RLOAD;
      slcp_pkg::S_RDIV:  cmd.op = slcp_pkg::OP_DIVSTEP;
      slcp_pkg::S_OUT:   cmd.op = sts.out_free ? slcp_pkg::OP_OUT : slcp_pkg::OP_NONE;
      default:           cmd.op = slcp_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/core/slcp_dpath.sv */
// Datapath for the class probability unit: weight memory, score accumulator,
// exponential series, shared divider, sums and output register.
// Depends on slcp_pkg; driven by slcp_ctrl.
module slcp_dpath #(
  parameter int WEIGHT_COUNT = slcp_pkg::WEIGHT_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  slcp_pkg::cmd_t                     cmd,
  input  logic                               in_valid,
  input  logic                               in_kind,
  input  logic [slcp_pkg::IDX_W-1:0]         in_index,
  input  logic signed [slcp_pkg::WGT_W-1:0]  in_weight,
  input  logic                               in_no_feature,
  input  logic                               in_is_target,
  input  logic                               in_last_class,
  input  logic                               in_last_example,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [slcp_pkg::PROB_W-1:0]        out_prob,
  output logic                               out_clamped,
  output slcp_pkg::status_t                  sts
);

  localparam int AW = $clog2(WEIGHT_COUNT);
  localparam int IW = (AW > slcp_pkg::IDX_W) ? AW : slcp_pkg::IDX_W;

  logic signed [slcp_pkg::WGT_W-1:0] mem [WEIGHT_COUNT];
  logic signed [slcp_pkg::WGT_W-1:0] rdata_r;
  logic [IW-1:0]  idx_ext;
  logic           idx_ok;
  logic           fire;
  logic           rd_ok_r, nf_r, tg_r, lc_r, le_r;

  logic signed [slcp_pkg::WGT_W-1:0] score_r;
  logic           clamp_r, neg_r, second_r;
  logic [4:0]     n_r;
  logic [3:0]     kidx_r;
  logic [slcp_pkg::TERM_W-1:0] z_r, term_r;
  logic [slcp_pkg::SER_W-1:0]  sum_r, e1_r;
  logic [slcp_pkg::SUM_W-1:0]  p_r, e_r, num_r, den_r, rem_r, dvs_r;
  logic [slcp_pkg::ACC_W-1:0]  acc_r;
  logic [66:0]    rp_r;
  logic [slcp_pkg::DVD_W-1:0]  dvd_r, quo_r;
  logic [6:0]     cnt_r;
  logic           out_valid_r, out_clamped_r;
  logic [slcp_pkg::PROB_W-1:0] out_prob_r;

  logic [31:0]    mul_x, mul_y;
  logic [63:0]    mprod;
  logic signed [slcp_pkg::WGT_W:0] score_sum;
  logic signed [slcp_pkg::WGT_W-1:0] w_add, s_cl;
  logic [20:0]    a_mag;
  logic [slcp_pkg::TERM_W-1:0] mq, q0, q_fix;
  logic [35:0]    rchk;
  logic [4:0]     kval;
  logic [slcp_pkg::SER_W-1:0]  sum_nxt;
  logic [slcp_pkg::ACC_W-1:0]  acc_hi;
  logic [56:0]    rem_sh;
  logic           ge;
  logic [slcp_pkg::SUM_W-1:0]  e_sel;
  logic [56:0]    den_add, num_add;

  assign fire    = cmd.accept_en && in_valid;
  assign idx_ext = IW'(in_index);
  assign idx_ok  = ({1'b0, idx_ext} < (IW+1)'(WEIGHT_COUNT));

  always_ff @(posedge clk) begin
    if (fire && !in_kind && idx_ok) begin
      mem[idx_ext[AW-1:0]] <= in_weight;
    end
    if (fire) begin
      rdata_r <= mem[idx_ext[AW-1:0]];
    end
  end

  always_comb begin
    mul_x = {1'b0, term_r};
    mul_y = {1'b0, z_r};
    if (cmd.op == slcp_pkg::OP_PMLO) begin
      mul_x = p_r[31:0];
      mul_y = e1_r;
    end else if (cmd.op == slcp_pkg::OP_PMHI) begin
      mul_x = {8'd0, p_r[55:32]};
      mul_y = e1_r;
    end
  end
  assign mprod = mul_x * mul_y;

  assign w_add     = (rd_ok_r && !nf_r) ? rdata_r : '0;
  assign score_sum = (slcp_pkg::WGT_W+1)'(score_r) + (slcp_pkg::WGT_W+1)'(w_add);

  always_comb begin
    s_cl = score_r;
    if (score_r > slcp_pkg::CLAMP_HI) s_cl = slcp_pkg::CLAMP_HI;
    if (score_r < slcp_pkg::CLAMP_LO) s_cl = slcp_pkg::CLAMP_LO;
  end
  assign a_mag = s_cl[slcp_pkg::WGT_W-1] ? 21'(-s_cl) : 21'(s_cl);

  assign mq    = acc_r[60:30];
  assign kval  = 5'(kidx_r) + 5'd1;
  assign q0    = rp_r[65:35];
  assign rchk  = 36'(mq) - 36'(q0) * 36'(kval);
  assign q_fix = (rchk >= 36'(kval)) ? q0 + 31'd1 : q0;
  assign sum_nxt = sum_r + 32'(q_fix);
  assign acc_hi  = acc_r + {mprod[55:0], 32'd0};

  assign rem_sh = {rem_r, dvd_r[slcp_pkg::DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  assign e_sel   = neg_r ? quo_r[slcp_pkg::SUM_W-1:0] : e_r;
  assign den_add = {1'b0, den_r} + {1'b0, e_sel};
  assign num_add = {1'b0, num_r} + {1'b0, e_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r     <= '0;
      num_r       <= '0;
      den_r       <= '0;
      clamp_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == slcp_pkg::OP_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        slcp_pkg::OP_ACC: begin
          if (score_sum > (slcp_pkg::WGT_W+1)'(25'sd8388607)) score_r <= 24'sd8388607;
          else if (score_sum < -25'sd8388608) score_r <= -24'sd8388608;
          else score_r <= score_sum[slcp_pkg::WGT_W-1:0];
        end
        slcp_pkg::OP_CLAMP: begin
          score_r <= '0;
          if (score_r > slcp_pkg::CLAMP_HI || score_r < slcp_pkg::CLAMP_LO) clamp_r <= 1'b1;
        end
        slcp_pkg::OP_ADD: begin
          den_r <= den_add[56] ? '1 : den_add[55:0];
          if (tg_r) num_r <= num_add[56] ? '1 : num_add[55:0];
        end
        slcp_pkg::OP_OUT: begin
          num_r       <= '0;
          den_r       <= '0;
          clamp_r     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_kind) begin
      rd_ok_r <= idx_ok;
      nf_r    <= in_no_feature;
      tg_r    <= in_is_target;
      lc_r    <= in_last_class;
      le_r    <= in_last_example;
    end
    case (cmd.op)
      slcp_pkg::OP_CLAMP: begin
        neg_r    <= s_cl[slcp_pkg::WGT_W-1];
        n_r      <= a_mag[20:16];
        z_r      <= {a_mag[15:0], 14'd0} & 31'h3FFF_FFFF;
        term_r   <= slcp_pkg::ONE_Q30;
        sum_r    <= 32'(slcp_pkg::ONE_Q30);
        kidx_r   <= '0;
        second_r <= 1'b0;
      end
      slcp_pkg::OP_SMUL: acc_r <= 88'(mprod) + 88'(32'h2000_0000);
      slcp_pkg::OP_SRCP: rp_r <= 67'(mq) * 67'(slcp_pkg::RECIP_TBL[kidx_r]);
      slcp_pkg::OP_SSTEP: begin
        term_r <= q_fix;
        sum_r  <= sum_nxt;
        kidx_r <= kidx_r + 4'd1;
        if (kidx_r == 4'd15) begin
          if (!second_r) begin
            p_r      <= 56'(sum_nxt);
            second_r <= 1'b1;
            z_r      <= slcp_pkg::ONE_Q30;
            term_r   <= slcp_pkg::ONE_Q30;
            sum_r    <= 32'(slcp_pkg::ONE_Q30);
          end else begin
            e1_r <= sum_nxt;
          end
        end
      end
      slcp_pkg::OP_PMLO: acc_r <= 88'(mprod) + 88'(32'h2000_0000);
      slcp_pkg::OP_PMHI: begin
        p_r <= acc_hi[85:30];
        n_r <= n_r - 5'd1;
      end
      slcp_pkg::OP_FIN: begin
        e_r   <= 56'(({1'b0, p_r} + 57'd32) >> 6);
        dvd_r <= (72'd1 << 54) + 72'(p_r >> 1);
        dvs_r <= p_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= 7'(slcp_pkg::DVD_W);
      end
      slcp_pkg::OP_RLOAD: begin
        dvd_r <= {num_r, 16'd0};
        dvs_r <= den_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= 7'(slcp_pkg::DVD_W);
      end
      slcp_pkg::OP_DIVSTEP: begin
        rem_r <= ge ? 56'(rem_sh - {1'b0, dvs_r}) : rem_sh[55:0];
        quo_r <= {quo_r[slcp_pkg::DVD_W-2:0], ge};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - 7'd1;
      end
      slcp_pkg::OP_OUT: begin
        out_clamped_r <= clamp_r;
        if (den_r == '0) out_prob_r <= '0;
        else if (|quo_r[slcp_pkg::DVD_W-1:16]) out_prob_r <= '1;
        else out_prob_r <= quo_r[15:0];
      end
      default: ;
    endcase
  end

  assign sts.closing       = lc_r || le_r;
  assign sts.last_ex       = le_r;
  assign sts.series_last   = (kidx_r == 4'd15);
  assign sts.series_second = second_r;
  assign sts.n_zero        = (n_r == '0);
  assign sts.neg           = neg_r;
  assign sts.div_last      = (cnt_r == 7'd1);
  assign sts.out_free      = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_prob    = out_prob_r;
  assign out_clamped = out_clamped_r;

  a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n) num_r <= den_r)
    else $error("numerator sum exceeds denominator sum");
  a_out_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == slcp_pkg::OP_OUT |-> le_r)
    else $error("result issued without example end");
  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == slcp_pkg::OP_OUT |=> num_r == '0 && den_r == '0 && !clamp_r)
    else $error("sums not cleared after result");

endmodule

/* rtl/core/sparse_loglinear_class_probability_unit.sv */
// Top level of the sparse log-linear class probability unit.
// Instantiates slcp_ctrl and slcp_dpath; depends on slcp_pkg.
//
// Usage: one input stream carries weight writes (in_tuser = 0) and feature
// items (in_tuser = 1), grouped by class; in_tlast marks the final class of
// an example. One result transfer follows each example on the out_ stream.
// A weight write leaves the unit idle. A feature item takes a weight memory
// read, then the saturating score add. A class end adds the exponential: two
// 16-term series on one 32x32 multiplier and a reciprocal multiplier, a
// multiply by e in low and high halves per integer unit of the score, a
// finish step, the shared divider for a negative score, and the update of
// the sums. An example end adds the probability divide on the same divider,
// then loads the result into the output register. Reset clears the score,
// sums, clamp flag and control and holds in_tready low; the weight memory
// holds no reset value and must be written before use. While the receiver
// stalls, the result waits in the output register and the block keeps taking
// items until the next result is due.
module sparse_loglinear_class_probability_unit #(
  parameter int WEIGHT_COUNT = slcp_pkg::WEIGHT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // feature_index, weight_value, no_feature,
                                  // is_target, last_in_class, zero pad
  input  logic        in_tuser,   // kind
  input  logic        in_tlast,   // last_in_example
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // probability
  output logic        out_tuser   // score_clamped
);

  slcp_pkg::cmd_t    cmd;
  slcp_pkg::status_t sts;

  assign in_tready = cmd.accept_en;

  slcp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && cmd.accept_en),
    .in_kind (in_tuser),
    .sts     (sts),
    .cmd     (cmd)
  );

  slcp_dpath #(
    .WEIGHT_COUNT (WEIGHT_COUNT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_valid        (in_tvalid),
    .in_kind         (in_tuser),
    .in_index        (in_tdata[11:0]),
    .in_weight       (in_tdata[35:12]),
    .in_no_feature   (in_tdata[36]),
    .in_is_target    (in_tdata[37]),
    .in_last_class   (in_tdata[38]),
    .in_last_example (in_tlast),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_prob        (out_tdata),
    .out_clamped     (out_tuser),
    .sts             (sts)
  );

endmodule

/* tb/slcp_checker.sv */
`timescale 1ns / 100ps
// Checker for the sparse log-linear class probability unit: watches both
// stream channels, predicts each probability result and compares it.
// Depends on nothing but the channel signals it is connected to.
module slcp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] probability;
    logic        clamped;
  } prob_result_t;

  prob_result_t       expected_probs[$];
  logic signed [23:0] weight_mem[4096];
  int                 score;
  logic [63:0]        num_sum;
  logic [63:0]        den_sum;
  logic               clamp_flag;

  function automatic logic [63:0] mul_q30(logic [63:0] x, logic [63:0] y);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y} + (128'd1 << 29);
    return prod[93:30];
  endfunction

  function automatic logic [63:0] exp_series(logic [63:0] z);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 30;
    sum = term;
    for (int k = 1; k <= 16; k++) begin
      term = mul_q30(term, z) / k;
      sum += term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] exp_q24(int s);
    int          a;
    int          n;
    logic [63:0] p;
    logic [63:0] e1;
    a = (s < 0) ? -s : s;
    n = (a >> 16) & 31;
    p = exp_series({34'd0, a[15:0], 14'd0});
    e1 = exp_series(64'd1 << 30);
    for (int i = 0; i < n; i++) p = mul_q30(p, e1);
    if (s >= 0) return (p + 64'd32) >> 6;
    return ((64'd1 << 54) + (p >> 1)) / p;
  endfunction

  function automatic logic [63:0] add_sat56(logic [63:0] acc, logic [63:0] v);
    logic [63:0] r;
    r = acc + v;
    return (r > ((64'd1 << 56) - 1)) ? ((64'd1 << 56) - 1) : r;
  endfunction

  function automatic logic [15:0] ratio_q16(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = num;
    if (den == 0) return 16'd0;
    if (r >= den) begin
      q = 1;
      r -= den;
    end
    if (r >= den) return 16'hFFFF;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic take_item(logic [39:0] d, logic kind, logic ex_end);
    logic [11:0]  idx;
    int           s;
    logic [63:0]  e;
    prob_result_t r;
    idx = d[11:0];
    if (!kind) begin
      weight_mem[idx] = d[35:12];
      return;
    end
    if (!d[36]) begin
      s = score + int'(weight_mem[idx]);
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      score = s;
    end
    if (d[38] || ex_end) begin
      s = score;
      if (s > 1048575) begin
        s = 1048575;
        clamp_flag = 1'b1;
      end
      if (s < -1048576) begin
        s = -1048576;
        clamp_flag = 1'b1;
      end
      e = exp_q24(s);
      den_sum = add_sat56(den_sum, e);
      if (d[37]) num_sum = add_sat56(num_sum, e);
      score = 0;
    end
    if (ex_end) begin
      r.probability = ratio_q16(num_sum, den_sum);
      r.clamped = clamp_flag;
      expected_probs = {expected_probs, r};
      num_sum = 0;
      den_sum = 0;
      clamp_flag = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    prob_result_t want;
    if (!rst_n) begin
      score = 0;
      num_sum = 0;
      den_sum = 0;
      clamp_flag = 1'b0;
      expected_probs.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) take_item(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_probs.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual prob %0d clamp %0b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expected_probs.pop_front();
          if (want.probability !== out_tdata) begin
            $display("%0t: probability mismatch: expected %0d, actual %0d",
                     $time, want.probability, out_tdata);
            fail_count++;
          end
          if (want.clamped !== out_tuser) begin
            $display("%0t: clamp flag mismatch: expected %0b, actual %0b",
                     $time, want.clamped, out_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = expected_probs.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the sparse log-linear class probability unit: drives
// weight writes and class feature streams with bursty timing and a stalling
// receiver. Depends on slcp_checker and the unit's RTL.
module tb;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic [11:0] written[$];

  always #2 clk = ~clk;

  sparse_loglinear_class_probability_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  slcp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver alternates between always ready, long stalls and random stalls.
  always @(posedge clk) begin
    int mode;
    int left;
    if (left <= 0) begin
      mode = $urandom_range(0, 2);
      left = (mode == 1) ? $urandom_range(1, 300) : $urandom_range(1, 200);
    end
    left--;
    case (mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'b0;
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send(logic kind, logic [11:0] idx, logic [23:0] w, logic nf,
                      logic tg, logic lc, logic le);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tlast <= le;
    in_tdata <= {1'b0, lc, tg, nf, w, idx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_weight(logic [11:0] idx, logic [23:0] w);
    send(1'b0, idx, w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    written = {written, idx};
  endtask

  function automatic logic [11:0] known_index();
    return written[$urandom_range(0, written.size() - 1)];
  endfunction

  task automatic random_example();
    int          classes;
    int          feats;
    logic        close_ex;
    logic        lc;
    classes = $urandom_range(1, 8);
    for (int c = 0; c < classes; c++) begin
      feats = $urandom_range(1, 4);
      for (int f = 0; f < feats; f++) begin
        close_ex = (c == classes - 1) && (f == feats - 1);
        lc = (f == feats - 1);
        if (close_ex && $urandom_range(0, 4) == 0) lc = 1'b0;
        send(1'b1, known_index(), 24'($urandom), $urandom_range(0, 9) == 0,
             1'($urandom_range(0, 1)), lc, close_ex);
      end
    end
  endtask

  initial begin
    int n;
    logic [23:0] w;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_weight(12'd0, 24'h7FFFFF);
    write_weight(12'd4095, 24'h800000);
    write_weight(12'd1, 24'h000000);
    write_weight(12'd2, 24'h010000);
    write_weight(12'd3, 24'hFD8000);
    write_weight(12'hAAA, 24'h555555);
    write_weight(12'h555, 24'hAAAAAA);
    // Saturating score against a class with no features.
    send(1'b1, 12'd0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send(1'b1, 12'd0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b0);
    send(1'b1, 12'd1, 24'd0, 1'b1, 1'b0, 1'b1, 1'b1);
    // Saturating negative score, then a target at exactly one.
    send(1'b1, 12'd4095, 24'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    send(1'b1, 12'd4095, 24'd0, 1'b0, 1'b0, 1'b1, 1'b0);
    send(1'b1, 12'd2, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1);
    // Target flag set only on a non-closing item; example end closes a class.
    send(1'b1, 12'd3, 24'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    send(1'b1, 12'd1, 24'd0, 1'b0, 1'b0, 1'b1, 1'b0);
    send(1'b1, 12'hAAA, 24'd0, 1'b0, 1'b1, 1'b0, 1'b1);
    send(1'b1, 12'h555, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1);

    while (items_sent < 1750) begin
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        w = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                        : 24'($signed($urandom_range(0, 393216)) - 196608);
        write_weight(12'($urandom), w);
      end
      random_example();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
